// ===== rtl/kst_pkg.sv =====
// ---------------------------------------------------------------------------
// kst_pkg: shared types and constants for the k-smallest and mean tracker
// Word formats, cell link type and arithmetic widths used by all modules.
// ---------------------------------------------------------------------------
`default_nettype none

package kst_pkg;

    // number of kept prices, one cell each
    localparam int KEEP_SMALLEST = 5;

    localparam int PRICE_W  = 16;
    localparam int SUM_W    = 32;
    localparam int CNT_W    = 16;
    localparam int FRAC_W   = 8;
    localparam int MEAN_W   = 24;
    localparam int KEPT_W   = 3;
    localparam int DIVD_W   = SUM_W + FRAC_W;
    localparam int DIVC_W   = $clog2(DIVD_W);

    // mean clamp, 65535.0 in 16.8 fixed point
    localparam logic [MEAN_W-1:0] MEAN_MAX = 24'hFFFF00;

    // input word
    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic               seller_present;
        logic               is_sell_order;
        logic               end_of_list;
    } ord_word_t;

    // result word
    typedef struct packed {
        logic               found;
        logic [MEAN_W-1:0]  mean_price;
        logic [KEPT_W-1:0]  kept_total;
        logic [PRICE_W-1:0] smallest_first;
        logic [PRICE_W-1:0] smallest_second;
        logic [PRICE_W-1:0] smallest_third;
        logic [PRICE_W-1:0] smallest_fourth;
        logic [PRICE_W-1:0] smallest_fifth;
    } res_word_t;

    // what one cell hands to its right neighbor
    typedef struct packed {
        logic               disp;
        logic               valid;
        logic [PRICE_W-1:0] value;
    } cell_link_t;

    // controls shared by all cells
    typedef struct packed {
        logic ins;
        logic clr;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/kst_cell.sv =====
// ---------------------------------------------------------------------------
// kst_cell: one slot of the sorted insertion chain
// Holds one kept price. On insert it is displaced when empty or larger than
// the new price, then takes the left value or the new price.
// ---------------------------------------------------------------------------
`default_nettype none

module kst_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire kst_pkg::cell_ctl_t          ctl,
    input  wire logic [kst_pkg::PRICE_W-1:0] price,
    input  wire kst_pkg::cell_link_t         left,
    output kst_pkg::cell_link_t              right
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [kst_pkg::PRICE_W-1:0] value_reg;
    logic [kst_pkg::PRICE_W-1:0] value_next;
    logic                        disp;

    // displaced when empty or strictly larger (equal prices stay in front)
    assign disp = !valid_reg || (value_reg > price);

    assign right.disp  = disp;
    assign right.valid = valid_reg;
    assign right.value = value_reg;

    // next slot contents
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctl.clr)
        begin
            valid_next = 1'b0;
            value_next = '0;
        end
        else if (ctl.ins && disp)
        begin
            valid_next = valid_reg | left.valid;
            value_next = left.disp ? left.value : price;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            value_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            value_reg <= value_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kst_divider.sv =====
// ---------------------------------------------------------------------------
// kst_divider: bit-serial restoring divider
// One quotient bit per cycle; done pulses with the quotient held after.
// ---------------------------------------------------------------------------
`default_nettype none

module kst_divider (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [kst_pkg::DIVD_W-1:0] dividend,
    input  wire logic [kst_pkg::CNT_W-1:0]  divisor,
    output logic                            done,
    output logic [kst_pkg::DIVD_W-1:0]      quotient
);

    localparam logic [kst_pkg::DIVC_W-1:0] LAST_STEP = kst_pkg::DIVC_W'(kst_pkg::DIVD_W - 1);

    logic                        run_reg;
    logic                        run_next;
    logic                        done_reg;
    logic                        done_next;
    logic [kst_pkg::DIVC_W-1:0]  cnt_reg;
    logic [kst_pkg::DIVC_W-1:0]  cnt_next;
    logic [kst_pkg::CNT_W-1:0]   rem_reg;
    logic [kst_pkg::CNT_W-1:0]   rem_next;
    logic [kst_pkg::DIVD_W-1:0]  q_reg;
    logic [kst_pkg::DIVD_W-1:0]  q_next;
    logic [kst_pkg::CNT_W-1:0]   dvs_reg;
    logic [kst_pkg::CNT_W-1:0]   dvs_next;
    logic [kst_pkg::CNT_W:0]     trial;
    logic [kst_pkg::CNT_W:0]     diff;
    logic                        ge;

    // one trial subtract per cycle
    assign trial = {rem_reg, q_reg[kst_pkg::DIVD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            q_next   = dividend;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[kst_pkg::CNT_W-1:0] : trial[kst_pkg::CNT_W-1:0];
            q_next   = {q_reg[kst_pkg::DIVD_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ===== rtl/k_smallest_and_mean_tracker_core.sv =====
// ---------------------------------------------------------------------------
// k_smallest_and_mean_tracker_core: streaming five smallest prices and mean
// Qualifying orders feed a sum, a count and a chain of sorted cells; the
// end of a list produces one result word with the 16.8 mean.
// ---------------------------------------------------------------------------
//
//  channel | signals               | direction | word
//  --------+-----------------------+-----------+------------------
//  ord     | ord, ord_valid        | in        | kst_pkg::ord_word_t
//          | ord_stall             | out       |
//  res     | res, res_valid        | out       | kst_pkg::res_word_t
//          | res_stall             | in        |
//
//  a new word is taken each cycle while ord_stall is low
//  an end_of_list word holds ord_stall high while the sequencer snapshots and
//  clears the tracker, waits on the bit-serial divider, captures the mean and
//  loads res
//  the load into res waits while an earlier result word sits stalled there
//  the next list may start while the previous result waits on res_stall
//  reset clears all tracker state; no clearing pass is needed
// ---------------------------------------------------------------------------
`default_nettype none

module k_smallest_and_mean_tracker_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire kst_pkg::ord_word_t ord,
    input  wire logic               ord_valid,
    output logic                    ord_stall,
    output kst_pkg::res_word_t      res,
    output logic                    res_valid,
    input  wire logic               res_stall
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FIN  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [kst_pkg::SUM_W-1:0]   sum_reg;
    logic [kst_pkg::SUM_W-1:0]   sum_next;
    logic [kst_pkg::CNT_W-1:0]   count_reg;
    logic [kst_pkg::CNT_W-1:0]   count_next;
    kst_pkg::res_word_t          pend_reg;
    kst_pkg::res_word_t          pend_next;
    kst_pkg::res_word_t          out_reg;
    kst_pkg::res_word_t          out_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;

    logic                        take;
    logic                        qualify;
    logic                        res_free;
    logic [kst_pkg::SUM_W:0]     sum_wide;
    logic [kst_pkg::KEPT_W-1:0]  kept_cnt;
    logic                        div_done;
    logic [kst_pkg::DIVD_W-1:0]  div_q;
    logic [kst_pkg::MEAN_W-1:0]  mean_sat;
    kst_pkg::cell_ctl_t          ctl;
    kst_pkg::cell_link_t         link [kst_pkg::KEEP_SMALLEST+1];

    assign ord_stall = (state_reg != ST_IDLE);
    assign take      = ord_valid && !ord_stall;
    assign qualify   = take && ord.seller_present && ord.is_sell_order;
    assign res_free  = !out_valid_reg || !res_stall;

    // head of the chain: never displaced, always valid
    assign link[0].disp  = 1'b0;
    assign link[0].valid = 1'b1;
    assign link[0].value = '0;

    assign ctl.ins = qualify;
    assign ctl.clr = (state_reg == ST_FIN);

    // sorted insertion chain
    for (genvar i = 0; i < kst_pkg::KEEP_SMALLEST; i++)
    begin : g_cell
        kst_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .price (ord.price),
            .left  (link[i]),
            .right (link[i+1])
        );
    end

    // number of occupied cells
    always_comb
    begin
        kept_cnt = '0;
        for (int i = 1; i <= kst_pkg::KEEP_SMALLEST; i++)
        begin
            kept_cnt = kept_cnt + kst_pkg::KEPT_W'(link[i].valid);
        end
    end

    // mean divider
    kst_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.clr),
        .dividend ({sum_reg, {kst_pkg::FRAC_W{1'b0}}}),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // clamp quotient to 65535.0
    assign mean_sat = (div_q > kst_pkg::DIVD_W'(kst_pkg::MEAN_MAX)) ?
                      kst_pkg::MEAN_MAX : div_q[kst_pkg::MEAN_W-1:0];

    assign sum_wide = {1'b0, sum_reg} + kst_pkg::SUM_W'(ord.price);

    // tracker, sequencer and result register
    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (qualify)
        begin
            sum_next   = sum_wide[kst_pkg::SUM_W] ? '1 : sum_wide[kst_pkg::SUM_W-1:0];
            count_next = (count_reg == '1) ? count_reg : count_reg + 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (take && ord.end_of_list)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // snapshot the kept prices, then clear everything
                pend_next                 = '0;
                pend_next.found           = (count_reg != '0);
                pend_next.kept_total      = kept_cnt;
                pend_next.smallest_first  = link[1].value;
                pend_next.smallest_second = link[2].value;
                pend_next.smallest_third  = link[3].value;
                pend_next.smallest_fourth = link[4].value;
                pend_next.smallest_fifth  = link[5].value;
                sum_next                  = '0;
                count_next                = '0;
                state_next                = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    pend_next.mean_price = pend_reg.found ? mean_sat : '0;
                    state_next           = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign res       = out_reg;
    assign res_valid = out_valid_reg;

    // occupied cells always form a prefix of the chain
    for (genvar i = 2; i <= kst_pkg::KEEP_SMALLEST; i++)
    begin : g_chk
        a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
            link[i].valid |-> link[i-1].valid)
            else $error("kept cell valid above an empty cell");
    end

    // finishing a list leaves the tracker cleared
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |=> (sum_reg == '0 && count_reg == '0 && !link[1].valid))
        else $error("tracker not cleared after end of list");

    // a word with nothing found carries a zero mean and a zero kept total
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.found) |-> (res.mean_price == '0 && res.kept_total == '0))
        else $error("empty result carries data");

    // divider completes only while the sequencer waits for it
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside of its wait");

endmodule

`default_nettype wire
